// ===== rtl/core/mpq_pkg.sv =====
package mpq_pkg;

    localparam int MPQ_CAPACITY = 8;
    localparam int VALUE_W      = 16;
    localparam int STATUS_W     = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = 16'sh8000;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } mpq_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic [STATUS_W-1:0]       status;
    } mpq_rsp_t;

    // control from the sequencer to the minimum scanner
    typedef struct packed {
        logic step;
        logic first;
    } mpq_scan_ctl_t;

endpackage

// ===== rtl/core/mpq_ram.sv =====
module mpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mpq_minscan.sv =====
module mpq_minscan #(
    parameter int CAPACITY = 8
) (
    input  logic                                 clk,
    input  mpq_pkg::mpq_scan_ctl_t               ctl,
    input  logic signed [mpq_pkg::VALUE_W-1:0]   rd_value,
    input  logic [$clog2(CAPACITY)-1:0]          rd_addr,
    output logic signed [mpq_pkg::VALUE_W-1:0]   min_value,
    output logic [$clog2(CAPACITY)-1:0]          min_addr
);
    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic signed [VALUE_W-1:0] min_reg;
    logic [AW-1:0]             addr_reg;
    logic                      take;

    // strict compare keeps the earliest of equal minima
    assign take      = ctl.first || (rd_value < min_reg);
    assign min_value = take ? rd_value : min_reg;
    assign min_addr  = take ? rd_addr : addr_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            min_reg  <= min_value;
            addr_reg <= min_addr;
        end
    end

endmodule

// ===== rtl/core/min_priority_queue_core.sv =====
// channel | signals                    | direction | beat
// req     | req_valid, req_stall, req  | in        | kind, value
// rsp     | rsp_valid, rsp_stall, rsp  | out       | removed_value, status
//
// insert, or remove on an empty queue: the result is formed in the accept cycle and goes to the output register
// remove with n stored values: the accept cycle reads entry 0, then the scan state
// compares one ram read per stored entry; req_stall stays high through the scan
// the hole left by a remove is filled with the last entry in the same cycle
// after reset the queue is empty and takes a beat on the first cycle
// a stalled result is held in an output register; one more beat may be
// accepted and its result parks until the output register drains
module min_priority_queue_core #(
    parameter int CAPACITY = mpq_pkg::MPQ_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mpq_pkg::mpq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mpq_pkg::mpq_rsp_t rsp
);
    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [AW-1:0] tag_reg, tag_next;
    mpq_rsp_t      hold_reg, hold_next;
    mpq_rsp_t      rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          req_fire;
    logic          rsp_free;
    mpq_rsp_t      res;
    logic          res_ok;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] rd_value;

    mpq_scan_ctl_t             scan_ctl;
    logic signed [VALUE_W-1:0] scan_min;
    logic [AW-1:0]             scan_addr;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_value  = ram_rdata;

    mpq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mpq_minscan #(
        .CAPACITY(CAPACITY)
    ) u_minscan (
        .clk       (clk),
        .ctl       (scan_ctl),
        .rd_value  (rd_value),
        .rd_addr   (tag_reg),
        .min_value (scan_min),
        .min_addr  (scan_addr)
    );

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        tag_next       = tag_reg;
        hold_next      = hold_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = tag_reg + 1'b1;
        scan_ctl       = '0;
        res            = '0;
        res_ok         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (req_fire)
                begin
                    if (req.kind == KIND_INSERT)
                    begin
                        res_ok            = 1'b1;
                        res.removed_value = '0;
                        if (occ_reg == CW'(CAPACITY))
                        begin
                            res.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            res.status = ST_OK;
                            ram_we     = 1'b1;
                            ram_waddr  = occ_reg[AW-1:0];
                            ram_wdata  = req.value;
                            occ_next   = occ_reg + 1'b1;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        res_ok            = 1'b1;
                        res.removed_value = UNDERFLOW_VALUE;
                        res.status        = ST_UNDERFLOW;
                    end
                    else
                    begin
                        // entry 0 is being read this cycle
                        state_next = S_SCAN;
                        tag_next   = '0;
                    end
                end
            end
            S_SCAN:
            begin
                scan_ctl.step  = 1'b1;
                scan_ctl.first = (tag_reg == '0);
                if (CW'(tag_reg) == occ_reg - 1'b1)
                begin
                    // last entry is on the read port: move it into the hole
                    ram_we            = 1'b1;
                    ram_waddr         = scan_addr;
                    ram_wdata         = ram_rdata;
                    occ_next          = occ_reg - 1'b1;
                    res_ok            = 1'b1;
                    res.removed_value = scan_min;
                    res.status        = ST_OK;
                    state_next        = S_IDLE;
                end
                else
                begin
                    tag_next = tag_reg + 1'b1;
                end
            end
            S_HOLD:
            begin
                if (rsp_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_ok)
        begin
            if (rsp_free)
            begin
                rsp_next       = res;
                rsp_valid_next = 1'b1;
            end
            else
            begin
                hold_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            tag_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            tag_reg       <= tag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (occ_reg != '0) && (CW'(tag_reg) < occ_reg))
        else $error("scan outside stored entries");

    a_remove_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req.kind == KIND_REMOVE) && (occ_reg != '0) |=> (state_reg == S_SCAN))
        else $error("remove did not start a scan");

    a_occ_moves_on_work: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> ($past(req_fire) || ($past(state_reg) == S_SCAN)))
        else $error("occupancy changed with no beat in progress");

    a_hold_keeps_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> rsp_valid_reg)
        else $error("parked result with an empty output register");

endmodule
